>>> hw/rtl/mtx4_pkg.sv
// shared widths for the fixed-point matrix multiplier
package mtx4_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int PROD_W = 2 * DATA_W;

	// saturation limits of a signed data word
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

>>> hw/rtl/matrix4x4_multiply.sv
// DIM x DIM column-major matrix product in signed fixed point
//
// Load side: a transaction is taken when start is high and busy is low. Each
// transaction writes left_value and right_value into the left and right element
// memories at elem_index (row + DIM*column); an index past the last element is
// not written. A transaction with done_req set writes its pair and then starts
// the product; busy stays high until the last product element has been sent.
// Loads without done_req never raise busy.
// Result side: DIM*DIM elements come out in index order, one per strobe cycle,
// with last_out on the final one. The receiver cannot stall; each element is
// on the ports for exactly one cycle.
// Timing: one multiply-accumulate per cycle while a product runs. Busy falls with
// the strobe of the last element, and the next transaction can be taken once busy
// is low. The memory read, multiplier and accumulator each own one register stage.
// Sums are kept at full width, shifted right by FRAC_BITS and saturated to 32
// bits, with overflow flagging saturation.
// Reset clears the sequencer and strobe; the element memories are not cleared
// and must be written before they are used in a product.
module matrix4x4_multiply
	import mtx4_pkg::*;
#(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [DATA_W-1:0] left_value,
	input  logic signed [DATA_W-1:0] right_value,
	input  logic                     done_req,
	output logic                     strobe,
	output logic [IDX_W-1:0]         out_index,
	output logic signed [DATA_W-1:0] product_value,
	output logic                     overflow,
	output logic                     last_out
);

	localparam int CELLS = DIM * DIM;
	localparam int CW    = $clog2(CELLS);
	localparam int EW    = $clog2(DIM);
	localparam int IW    = ((CW > IDX_W) ? CW : IDX_W) + 1;
	localparam int ACC_W = PROD_W + $clog2(DIM) + 1;

	logic signed [DATA_W-1:0] left_mem  [CELLS];
	logic signed [DATA_W-1:0] right_mem [CELLS];

	logic          busy_q, run_q;
	logic [EW-1:0] e_q, x_q;
	logic [CW-1:0] pos_q, la_q, ra_q, rbase_q;

	logic          v_s1, first_s1, laste_s1, lastc_s1;
	logic [CW-1:0] pos_s1;
	logic signed [DATA_W-1:0] l_s1, r_s1;

	logic          v_s2, first_s2, laste_s2, lastc_s2;
	logic [CW-1:0] pos_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic          fin_s3, lastc_s3;
	logic [CW-1:0] pos_s3;
	logic signed [ACC_W-1:0] acc_s3;

	logic                  strobe_q, last_q, ovf_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DATA_W-1:0]     val_q;

	logic          accept, wr_en, e_wrap, x_wrap, c_last;
	logic [IW-1:0] idx_ext;
	logic [CW-1:0] waddr, rbase_nx;
	logic signed [ACC_W-1:0] shifted;
	logic [ACC_W-DATA_W:0]   top_bits;
	logic                    sat;

	assign accept  = start && !busy_q;
	assign idx_ext = IW'(elem_index);
	assign wr_en   = accept && (idx_ext < IW'(CELLS));
	assign waddr   = idx_ext[CW-1:0];

	assign e_wrap   = (e_q == EW'(DIM - 1));
	assign x_wrap   = (x_q == EW'(DIM - 1));
	assign c_last   = (pos_q == CW'(CELLS - 1));
	assign rbase_nx = rbase_q + CW'(DIM);

	// sequencer: y outer, x inner, e innermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			run_q   <= 1'b0;
			e_q     <= '0;
			x_q     <= '0;
			pos_q   <= '0;
			la_q    <= '0;
			ra_q    <= '0;
			rbase_q <= '0;
		end else begin
			if (accept && done_req) begin
				busy_q  <= 1'b1;
				run_q   <= 1'b1;
				e_q     <= '0;
				x_q     <= '0;
				pos_q   <= '0;
				la_q    <= '0;
				ra_q    <= '0;
				rbase_q <= '0;
			end else if (run_q) begin
				if (e_wrap) begin
					e_q   <= '0;
					pos_q <= pos_q + CW'(1);
					if (c_last)
						run_q <= 1'b0;
					if (x_wrap) begin
						x_q     <= '0;
						la_q    <= '0;
						rbase_q <= rbase_nx;
						ra_q    <= rbase_nx;
					end else begin
						x_q  <= x_q + EW'(1);
						la_q <= CW'(x_q) + CW'(1);
						ra_q <= rbase_q;
					end
				end else begin
					e_q  <= e_q + EW'(1);
					la_q <= la_q + CW'(DIM);
					ra_q <= ra_q + CW'(1);
				end
			end
			if (fin_s3 && lastc_s3)
				busy_q <= 1'b0;
		end
	end

	// element memories: write on load, registered read for the mac pipe
	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_mem[waddr]  <= left_value;
			right_mem[waddr] <= right_value;
		end
		if (run_q) begin
			l_s1 <= left_mem[la_q];
			r_s1 <= right_mem[ra_q];
		end
	end

	// pipeline control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			fin_s3   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			v_s1     <= run_q;
			v_s2     <= v_s1;
			fin_s3   <= v_s2 && laste_s2;
			strobe_q <= fin_s3;
		end
	end

	assign shifted  = acc_s3 >>> FRAC_BITS;
	assign top_bits = shifted[ACC_W-1:DATA_W-1];
	assign sat      = !((&top_bits) || !(|top_bits));

	always_ff @(posedge clk) begin
		first_s1 <= (e_q == '0);
		laste_s1 <= e_wrap;
		lastc_s1 <= c_last;
		pos_s1   <= pos_q;

		first_s2 <= first_s1;
		laste_s2 <= laste_s1;
		lastc_s2 <= lastc_s1;
		pos_s2   <= pos_s1;
		if (v_s1)
			prod_s2 <= PROD_W'(l_s1) * PROD_W'(r_s1);

		lastc_s3 <= lastc_s2;
		pos_s3   <= pos_s2;
		if (v_s2)
			acc_s3 <= (first_s2 ? '0 : acc_s3) + ACC_W'(prod_s2);

		idx_q  <= IDX_W'(pos_s3);
		last_q <= lastc_s3;
		ovf_q  <= sat;
		if (sat)
			val_q <= acc_s3[ACC_W-1] ? SAT_MIN : SAT_MAX;
		else
			val_q <= shifted[DATA_W-1:0];
	end

	assign busy          = busy_q;
	assign strobe        = strobe_q;
	assign out_index     = idx_q;
	assign product_value = val_q;
	assign overflow      = ovf_q;
	assign last_out      = last_q;

endmodule

>>> test/matrix4x4_multiply_tb.sv
// self-checking testbench for the fixed-point 4x4 matrix multiplier
`timescale 1ns / 1ps

module matrix4x4_multiply_tb
	import mtx4_pkg::*;
();

	localparam int GRID        = 4;
	localparam int FRAC        = 16;
	localparam int CELLS       = GRID * GRID;
	localparam int TOTAL_LOADS = 470;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 120;

	localparam logic signed [127:0] SUM_MAX = 128'sd2147483647;
	localparam logic signed [127:0] SUM_MIN = -128'sd2147483648;

	typedef struct {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;
		logic              done;
		logic              drain;
	} load_item_t;

	typedef struct {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] value;
		logic              ovf;
		logic              last;
	} product_elem_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [IDX_W-1:0]         elem_index = '0;
	logic signed [DATA_W-1:0] left_value = '0;
	logic signed [DATA_W-1:0] right_value = '0;
	logic                     done_req = 1'b0;
	logic                     strobe;
	logic [IDX_W-1:0]         out_index;
	logic signed [DATA_W-1:0] product_value;
	logic                     overflow;
	logic                     last_out;

	load_item_t    pending_loads[$];
	product_elem_t expected_products[$];
	load_item_t    next_load;

	logic signed [DATA_W-1:0] left_mem  [CELLS];
	logic signed [DATA_W-1:0] right_mem [CELLS];

	int loads_sent = 0;
	int loads_taken = 0;
	int products_run = 0;
	int elems_checked = 0;
	int sat_predicted = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	matrix4x4_multiply #(
		.DIM(GRID),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.elem_index(elem_index),
		.left_value(left_value),
		.right_value(right_value),
		.done_req(done_req),
		.strobe(strobe),
		.out_index(out_index),
		.product_value(product_value),
		.overflow(overflow),
		.last_out(last_out)
	);

	always #10 clk = ~clk;

	// store the pair and, on done, queue all sixteen product elements
	function automatic void predict_load(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] lval, input logic [DATA_W-1:0] rval,
			input logic done);
		logic signed [127:0] acc;
		logic signed [63:0]  term;
		logic signed [127:0] scaled;
		product_elem_t       elem;
		left_mem[idx] = lval;
		right_mem[idx] = rval;
		if (done) begin
			products_run++;
			for (int col = 0; col < GRID; col++) begin
				for (int row = 0; row < GRID; row++) begin
					acc = '0;
					for (int e = 0; e < GRID; e++) begin
						term = left_mem[IDX_W'(row + GRID * e)] *
							right_mem[IDX_W'(e + GRID * col)];
						acc = acc + term;
					end
					// arithmetic shift truncates toward minus infinity
					scaled = acc >>> FRAC;
					elem.index = IDX_W'(row + GRID * col);
					elem.last = (row + GRID * col == CELLS - 1);
					if (scaled > SUM_MAX) begin
						elem.value = SAT_MAX;
						elem.ovf = 1'b1;
					end else if (scaled < SUM_MIN) begin
						elem.value = SAT_MIN;
						elem.ovf = 1'b1;
					end else begin
						elem.value = scaled[DATA_W-1:0];
						elem.ovf = 1'b0;
					end
					if (elem.ovf)
						sat_predicted++;
					expected_products.push_back(elem);
				end
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// value mix: mostly small Q16.16 numbers, some near the saturation border,
	// some over the whole range including the extremes
	function automatic logic [DATA_W-1:0] pick_value(input int mode);
		logic [DATA_W-1:0] r;
		r = $urandom;
		if (mode < 6) begin
			case ($urandom_range(15))
				0: return '0;
				1: return '1;
				default: return {{12{r[19]}}, r[19:0]};
			endcase
		end else if (mode < 8) begin
			return {{8{r[23]}}, r[23:0]};
		end else begin
			case ($urandom_range(5))
				0: return SAT_MAX;
				1: return SAT_MIN;
				default: return r;
			endcase
		end
	endfunction

	function automatic void add_load(input int idx, input logic [DATA_W-1:0] lval,
			input logic [DATA_W-1:0] rval, input logic done, input logic drain);
		load_item_t it;
		it.index = IDX_W'(idx);
		it.left = lval;
		it.right = rval;
		it.done = done;
		it.drain = drain;
		pending_loads.push_back(it);
	endfunction

	function automatic int idle_share();
		if (loads_sent < TOTAL_LOADS / 3)
			return 32;
		else if (loads_sent < 2 * TOTAL_LOADS / 3)
			return 83;
		return 0;
	endfunction

	// driver: hold the current transaction until taken, then offer the next one
	always @(negedge clk) begin
		if (arst_n && !(start && loads_taken != loads_sent)) begin
			if (pending_loads.size() != 0 && $urandom_range(99) >= idle_share()
					&& !(pending_loads[0].drain && expected_products.size() != 0)) begin
				next_load = pending_loads.pop_front();
				start <= 1'b1;
				elem_index <= next_load.index;
				left_value <= next_load.left;
				right_value <= next_load.right;
				done_req <= next_load.done;
				loads_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted loads, compare every strobed element
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_load(elem_index, left_value, right_value, done_req);
				loads_taken++;
			end
			if (strobe) begin
				if (expected_products.size() == 0) begin
					$display("%0t: unexpected product element, index %0d value 0x%h",
						$time, out_index, product_value);
					mismatches++;
				end else begin
					check_field("out_index", expected_products[0].index, out_index);
					check_field("product_value", expected_products[0].value, product_value);
					check_field("overflow", expected_products[0].ovf, overflow);
					check_field("last_out", expected_products[0].last, last_out);
					void'(expected_products.pop_front());
					elems_checked++;
				end
			end
			if ((start && !busy) || strobe)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int  order[CELLS];
		int  n;
		int  tmp;
		int  j;
		int  kind;
		int  mode;
		logic drain;

		// directed: odd rows of the left matrix at the positive extreme, even rows
		// at the negative one, so both saturation directions show up
		for (int i = 0; i < CELLS; i++)
			add_load(i, i[0] ? SAT_MAX : SAT_MIN, SAT_MAX, i == CELLS - 1, 1'b0);
		// zero a pair and hold off until the first product has fully come out
		add_load(5, '0, '0, 1'b1, 1'b1);
		add_load(0, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
		add_load(10, SAT_MIN, SAT_MIN, 1'b1, 1'b0);
		// reload with small values so later products start from unsaturated sums
		for (int i = 0; i < CELLS; i++)
			add_load(i, pick_value(0), pick_value(0), i == CELLS - 1, 1'b0);

		while (pending_loads.size() < TOTAL_LOADS) begin
			kind = $urandom_range(9);
			mode = $urandom_range(9);
			drain = ($urandom_range(7) == 0);
			if (kind < 4) begin
				for (int i = 0; i < CELLS; i++)
					order[i] = i;
				for (int i = CELLS - 1; i > 0; i--) begin
					j = $urandom_range(i);
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (int k = 0; k < CELLS; k++)
					add_load(order[k], pick_value(mode), pick_value(mode), k == CELLS - 1,
						drain && k == 0);
			end else if (kind < 9) begin
				n = $urandom_range(6, 1);
				for (int k = 0; k < n; k++)
					add_load($urandom_range(CELLS - 1), pick_value(mode), pick_value(mode),
						k == n - 1, drain && k == 0);
			end else begin
				// loads that only update the stores
				n = $urandom_range(3, 1);
				for (int k = 0; k < n; k++)
					add_load($urandom_range(CELLS - 1), pick_value(mode), pick_value(mode),
						1'b0, 1'b0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_loads.size() == 0 && loads_taken == loads_sent
			&& expected_products.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d load transactions, %0d products with %0d elements checked",
			loads_taken, products_run, elems_checked);
		$display("%0d elements predicted saturated, %0d mismatches", sat_predicted, mismatches);
		if (mismatches == 0 && expected_products.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> matrix4x4_multiply.f
hw/rtl/mtx4_pkg.sv
hw/rtl/matrix4x4_multiply.sv
test/matrix4x4_multiply_tb.sv
